// ----- hdl/lcgr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcgr_pkg
// Shared constants and types for the ranged random number generator.
// ----------------------------------------------------------------------------
package lcgr_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned TakeW  = 16;
  localparam int unsigned IndexW = 2;
  localparam int unsigned CntW   = $clog2(TakeW);

  localparam logic [DataW-1:0] LcgMul    = 32'd214013;
  localparam logic [DataW-1:0] LcgAdd    = 32'd2531011;
  localparam logic [DataW-1:0] SeedReset = 32'd0;
  localparam logic [DataW-1:0] LowReset  = 32'd1;
  localparam logic [DataW-1:0] HighReset = 32'd100;

  typedef enum logic [IndexW-1:0] {
    CFG_SEED = 2'd0,
    CFG_LOW  = 2'd1,
    CFG_HIGH = 2'd2
  } cfg_idx_e;

endpackage

// ----- hdl/lcgr_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcgr interfaces
// Valid/ready channels for draw requests, results and register writes.
// ----------------------------------------------------------------------------
interface lcgr_draw_if;
  logic valid;
  logic ready;
  logic draw_request;

  modport source (output valid, output draw_request, input ready);
  modport sink   (input valid, input draw_request, output ready);
endinterface

interface lcgr_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] random_value;
  logic               span_error;

  modport source (output valid, output random_value, output span_error, input ready);
  modport sink   (input valid, input random_value, input span_error, output ready);
endinterface

interface lcgr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [31:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ----- hdl/lcgr_mod.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcgr_mod
// Restoring bit-serial remainder of a 16-bit dividend by a 32-bit divisor,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lcgr_mod import lcgr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [TakeW-1:0] dividend_i,
  input  logic [DataW-1:0] divisor_i,
  output logic             done_o,
  output logic [TakeW-1:0] remainder_o
);

  logic             busy_q, busy_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [TakeW-1:0] quo_q, quo_d;
  logic [TakeW-1:0] rem_q, rem_d;
  logic [TakeW:0]   trial;
  logic [DataW-1:0] trial_ext;
  logic [DataW-1:0] diff;
  logic             ge;

  assign trial     = {rem_q, quo_q[TakeW-1]};
  assign trial_ext = {{(DataW-TakeW-1){1'b0}}, trial};
  assign ge        = trial_ext >= divisor_i;
  assign diff      = trial_ext - divisor_i;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(TakeW - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      quo_d = {quo_q[TakeW-2:0], ge};
      rem_d = ge ? diff[TakeW-1:0] : trial[TakeW-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o      = busy_q && (cnt_q == '0);
  assign remainder_o = rem_q;

endmodule

// ----- hdl/lcg_random_in_range.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg_random_in_range
// Draws from a 32-bit linear congruential generator reduced into a range.
// ----------------------------------------------------------------------------
// draws are accepted only in the idle state, so a new draw waits until the last
// result is loaded; the 16-step bit-serial remainder runs unless the span is zero
// a word with draw_request low is taken while idle and gives no result
// reset: generator state 0, low bound 1, high bound 100, no result pending
module lcg_random_in_range import lcgr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  lcgr_draw_if.sink  draw_i,
  lcgr_result_if.source result_o,
  lcgr_cfg_if.sink   cfg_i
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_STEP = 5'b00010,
    ST_LOAD = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_SUM  = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [DataW-1:0] gen_q, gen_d;
  logic [DataW-1:0] low_q, high_q;
  logic [DataW-1:0] span_q;
  logic             err_q;
  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] out_value_q;
  logic             out_err_q;
  logic             load_out;
  logic [DataW-1:0] rem_ext;
  logic [TakeW-1:0] remainder;
  logic             cfg_fire;
  logic             mod_start;
  logic             mod_done;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid;

  assign draw_i.ready = (state_q == ST_IDLE);

  lcgr_mod u_mod (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (mod_start),
    .dividend_i  (gen_q[DataW-1:DataW-TakeW]),
    .divisor_i   (span_q),
    .done_o      (mod_done),
    .remainder_o (remainder)
  );

  assign mod_start = (state_q == ST_LOAD) && (span_q != '0);
  assign load_out  = (state_q == ST_SUM) && (!out_valid_q || result_o.ready);
  assign rem_ext   = err_q ? '0 : {{(DataW-TakeW){1'b0}}, remainder};

  always_comb begin
    state_d = state_q;
    gen_d   = gen_q;
    unique case (state_q)
      ST_IDLE: begin
        if (draw_i.valid && draw_i.draw_request) begin
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        gen_d   = gen_q * LcgMul + LcgAdd;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        state_d = (span_q == '0) ? ST_SUM : ST_DIV;
      end
      ST_DIV: begin
        if (mod_done) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (cfg_fire && (cfg_i.reg_index == CFG_SEED)) begin
      gen_d = cfg_i.wdata;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gen_q       <= SeedReset;
      low_q       <= LowReset;
      high_q      <= HighReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gen_q       <= gen_d;
      out_valid_q <= out_valid_d;
      if (cfg_fire) begin
        unique case (cfg_i.reg_index)
          CFG_LOW:  low_q  <= cfg_i.wdata;
          CFG_HIGH: high_q <= cfg_i.wdata;
          default:  ;
        endcase
      end
    end
  end

  // span taken while the generator steps, zero-span flag in the load state, result on load
  always_ff @(posedge clk_i) begin
    if (state_q == ST_STEP) begin
      span_q <= high_q - low_q + 1'b1;
    end
    if (state_q == ST_LOAD) begin
      err_q <= (span_q == '0);
    end
    if (load_out) begin
      out_value_q <= rem_ext + low_q;
      out_err_q   <= err_q;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.random_value = signed'(out_value_q);
  assign result_o.span_error   = out_err_q;

endmodule

// ----- test/tb_lcg_random_in_range.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lcg_random_in_range
// Checks the ranged random generator against a cycle-free model of the
// generator state and the span reduction. A short table of directed words
// covers reset values, span extremes, zero span, inverted bounds and an
// unused register index. Random draws follow under three idle profiles.
// ----------------------------------------------------------------------------
module tb_lcg_random_in_range import lcgr_pkg::*; ();

  localparam int unsigned            CycleLimit  = 1_000_000;
  localparam int unsigned            DrainCycles = 25;
  localparam int unsigned            NoisePct    = 10;
  localparam int unsigned            DrawsPerPhase = 550;
  localparam int unsigned            DirRows     = 26;
  localparam logic [IndexW-1:0]      CfgBadIdx   = 2'd3;

  typedef enum logic [1:0] {
    ROW_DRAW,
    ROW_CHECK,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [IndexW-1:0] idx;
    logic [DataW-1:0]  data;
    logic              err;
  } stim_row_t;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    err;
  } draw_result_t;

  logic clk;
  logic rst_n;

  lcgr_draw_if   draw_if ();
  lcgr_result_if res_if ();
  lcgr_cfg_if    cfg_if ();

  lcg_random_in_range DUT (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .draw_i  (draw_if),
    .result_o(res_if),
    .cfg_i   (cfg_if)
  );

  logic [DataW-1:0] gen_state;
  logic [DataW-1:0] bound_lo;
  logic [DataW-1:0] bound_hi;
  draw_result_t     pending_draws [$];
  int unsigned      src_idle_pct;
  int unsigned      snk_idle_pct;
  int unsigned      fail_cnt;
  int unsigned      cycle_cnt;
  stim_row_t        dir_tbl [DirRows];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("tb_lcg_random_in_range NOT OK");
      $finish;
    end
  end

  function automatic draw_result_t draw_in_range();
    draw_result_t     res;
    logic [DataW-1:0] span;
    logic [TakeW-1:0] taken;
    gen_state = gen_state * LcgMul + LcgAdd;
    taken     = gen_state[DataW-1 -: TakeW];
    span      = bound_hi - bound_lo + 32'd1;
    if (span == '0) begin
      res.value = bound_lo;
      res.err   = 1'b1;
    end else begin
      res.value = ({{(DataW-TakeW){1'b0}}, taken} % span) + bound_lo;
      res.err   = 1'b0;
    end
    return res;
  endfunction

  function automatic stim_row_t draw_row(logic req);
    return '{kind: ROW_DRAW, idx: '0, data: {{(DataW-1){1'b0}}, req}, err: 1'b0};
  endfunction

  function automatic stim_row_t check_row(logic [DataW-1:0] value, logic err);
    return '{kind: ROW_CHECK, idx: '0, data: value, err: err};
  endfunction

  function automatic stim_row_t cfg_row(logic [IndexW-1:0] idx, logic [DataW-1:0] data);
    return '{kind: ROW_CFG, idx: idx, data: data, err: 1'b0};
  endfunction

  // result side: random back-pressure and in-order compare
  always @(posedge clk) begin
    res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    draw_result_t exp_res;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_draws.size() == 0) begin
        $error("unexpected result word: random_value %0d span_error %0b",
               res_if.random_value, res_if.span_error);
        fail_cnt++;
      end else begin
        exp_res = pending_draws.pop_front();
        if (res_if.random_value !== exp_res.value) begin
          $error("random_value: expected %0d, got %0d", exp_res.value,
                 res_if.random_value);
          fail_cnt++;
        end
        if (res_if.span_error !== exp_res.err) begin
          $error("span_error: expected %0b, got %0b", exp_res.err, res_if.span_error);
          fail_cnt++;
        end
      end
    end
  end

  task automatic send_draw(input logic req, input bit typed = 1'b0,
                           input logic [DataW-1:0] typed_value = '0,
                           input logic typed_err = 1'b0);
    draw_result_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      draw_if.valid <= 1'b0;
      @(posedge clk);
    end
    draw_if.valid        <= 1'b1;
    draw_if.draw_request <= req;
    do @(posedge clk); while (!draw_if.ready);
    if (req) begin
      res = draw_in_range();
      if (typed) begin
        res.value = typed_value;
        res.err   = typed_err;
      end
      pending_draws.push_back(res);
    end
  endtask

  // hold off draws until every result is back and the block is quiet
  task automatic wait_idle();
    draw_if.valid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IndexW-1:0] idx, input logic [DataW-1:0] data);
    wait_idle();
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wdata     <= data;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_SEED: gen_state = data;
      CFG_LOW:  bound_lo  = data;
      CFG_HIGH: bound_hi  = data;
      default: ;
    endcase
  endtask

  task automatic retune();
    logic [DataW-1:0] lo;
    logic [DataW-1:0] hi;
    case ($urandom_range(7))
      0: begin
        lo = $urandom;
        hi = lo + $urandom_range(1000);
      end
      1: begin
        lo = $urandom;
        hi = $urandom;
      end
      2: begin
        lo = $urandom;
        hi = lo - 32'd1;
      end
      3: begin
        lo = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        hi = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end
      4: begin
        lo = $urandom;
        hi = lo;
      end
      5: begin
        hi = $urandom;
        lo = hi + $urandom_range(1 << 20, 1);
      end
      6: begin
        lo = -$urandom_range(50);
        hi = $urandom_range(50);
      end
      default: begin
        lo = $urandom;
        hi = lo + $urandom_range(70000);
      end
    endcase
    case ($urandom_range(3))
      0: write_reg(CFG_SEED, $urandom);
      1: write_reg(CFG_SEED, $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000);
      default: ;
    endcase
    if ($urandom_range(9) == 0) write_reg(CfgBadIdx, $urandom);
    write_reg(CFG_LOW, lo);
    write_reg(CFG_HIGH, hi);
  endtask

  task automatic run_phase(input int unsigned src_pct, input int unsigned snk_pct);
    int unsigned drawn;
    int unsigned seg_len;
    logic        req;
    drawn        = 0;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    while (drawn < DrawsPerPhase) begin
      retune();
      seg_len = $urandom_range(60, 5);
      repeat (seg_len) begin
        req = ($urandom_range(99) >= NoisePct);
        send_draw(req);
        drawn++;
      end
    end
  endtask

  initial begin
    rst_n                = 1'b0;
    draw_if.valid        = 1'b0;
    draw_if.draw_request = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.reg_index     = '0;
    cfg_if.wdata         = '0;
    res_if.ready         = 1'b0;
    fail_cnt             = 0;
    cycle_cnt            = 0;
    gen_state            = SeedReset;
    bound_lo             = LowReset;
    bound_hi             = HighReset;
    src_idle_pct         = 7;
    snk_idle_pct         = 72;

    dir_tbl = '{
      check_row(32'd39, 1'b0),
      draw_row(1'b0),
      draw_row(1'b1),
      cfg_row(CFG_SEED, 32'hFFFF_FFFF),
      draw_row(1'b1),
      cfg_row(CFG_LOW, 32'h8000_0000),
      cfg_row(CFG_HIGH, 32'h7FFF_FFFF),
      check_row(32'h8000_0000, 1'b1),
      cfg_row(CFG_HIGH, 32'h7FFF_FFFE),
      draw_row(1'b1),
      cfg_row(CFG_LOW, 32'h0000_0000),
      cfg_row(CFG_HIGH, 32'hFFFF_FFFF),
      check_row(32'h0000_0000, 1'b1),
      cfg_row(CFG_LOW, 32'h7FFF_FFFF),
      cfg_row(CFG_HIGH, 32'h7FFF_FFFF),
      check_row(32'h7FFF_FFFF, 1'b0),
      cfg_row(CFG_LOW, 32'd5),
      cfg_row(CFG_HIGH, -32'sd5),
      draw_row(1'b1),
      draw_row(1'b0),
      cfg_row(CfgBadIdx, 32'h0000_0000),
      draw_row(1'b1),
      cfg_row(CFG_SEED, 32'h0000_0000),
      cfg_row(CFG_LOW, 32'd1),
      cfg_row(CFG_HIGH, 32'd100),
      check_row(32'd39, 1'b0)
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tbl[i]) begin
      case (dir_tbl[i].kind)
        ROW_DRAW:  send_draw(dir_tbl[i].data[0]);
        ROW_CHECK: send_draw(1'b1, 1'b1, dir_tbl[i].data, dir_tbl[i].err);
        default:   write_reg(dir_tbl[i].idx, dir_tbl[i].data);
      endcase
    end

    run_phase(7, 72);
    run_phase(72, 7);
    run_phase(0, 0);

    wait_idle();
    if (fail_cnt == 0) begin
      $display("tb_lcg_random_in_range OK");
    end else begin
      $display("tb_lcg_random_in_range NOT OK");
    end
    $finish;
  end

endmodule
